// ===== design/alwq_pkg.sv =====
// Shared types and constants for the aging longest-wait queue.
package alwq_pkg;

  localparam int ID_W   = 16;
  localparam int WAIT_W = 16;
  localparam int ENT_W  = ID_W + WAIT_W;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 32;

  localparam logic [WAIT_W-1:0] WAIT_MAX = {WAIT_W{1'b1}};

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_REMOVED  = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_AGE_RD = 7'b0000010,
    S_AGE_WR = 7'b0000100,
    S_MAX_RD = 7'b0001000,
    S_MAX_EV = 7'b0010000,
    S_REM_RD = 7'b0100000,
    S_REM_EV = 7'b1000000
  } state_t;

  typedef struct packed {
    logic [WAIT_W-1:0] inc;
    logic              gt;
    logic              eq;
  } alu_res_t;

endpackage

// ===== design/aging_longest_wait_queue.sv =====
// Aging longest-wait queue: sequencer, entry memory and output register.
// Insert: result register loaded on accept, then every entry, the new one included, is aged (read, write).
// Remove: maximum scan over all entries, then a pass that compacts kept entries and waits on output stalls.
// Full or empty: one result loaded on accept; ready again once the output register is free.
// Every entry goes through the one read port and the one wait unit, in a read and a write or evaluate state.
// Reset clears the count and control; the entry memory keeps its contents.
module aging_longest_wait_queue
  import alwq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,  // process_id, initial_wait
  input  logic [0:0]             s_tuser,  // func
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,  // out_id, out_wait
  output logic [1:0]             m_tuser,  // status
  output logic                   m_tlast   // last
);

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] keep, keep_next;
  logic [CW-1:0] nrem, nrem_next;
  logic [CW-1:0] done, done_next;
  logic [WAIT_W-1:0] max_wait, max_wait_next;
  logic [CW-1:0] idx_inc;

  logic [ENT_W-1:0] mem [QUEUE_DEPTH];
  logic [ENT_W-1:0] rd_data;
  logic             rd_en;
  logic             wr_en;
  logic [IW-1:0]    wr_addr;
  logic [ENT_W-1:0] wr_data;
  logic [ID_W-1:0]   rd_id;
  logic [WAIT_W-1:0] rd_wait;

  alu_res_t alu;

  logic out_free, accept, advance;
  logic load_out;
  logic [1:0]        o_status;
  logic [ID_W-1:0]   o_id;
  logic [WAIT_W-1:0] o_wait;
  logic              o_last;

  assign rd_id    = rd_data[ENT_W-1:WAIT_W];
  assign rd_wait  = rd_data[WAIT_W-1:0];
  assign idx_inc  = idx + CW'(1);
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;

  alwq_alu u_alu (
    .wait_in  (rd_wait),
    .ref_wait (max_wait),
    .res      (alu)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[idx[IW-1:0]];
    end
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    idx_next      = idx;
    keep_next     = keep;
    nrem_next     = nrem;
    done_next     = done;
    max_wait_next = max_wait;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = count[IW-1:0];
    wr_data       = {s_tdata[ID_W-1:0], s_tdata[ID_W+WAIT_W-1:ID_W]};
    load_out      = 1'b0;
    o_status      = ST_INSERTED;
    o_id          = '0;
    o_wait        = '0;
    o_last        = 1'b1;
    advance       = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          load_out = 1'b1;
          if (s_tuser[0] == FUNC_INSERT) begin
            if (count == CW'(QUEUE_DEPTH)) begin
              o_status = ST_FULL;
            end else begin
              wr_en      = 1'b1;
              count_next = count + CW'(1);
              idx_next   = '0;
              state_next = S_AGE_RD;
            end
          end else if (count == '0) begin
            o_status = ST_EMPTY;
          end else begin
            load_out   = 1'b0;
            idx_next   = '0;
            nrem_next  = '0;
            state_next = S_MAX_RD;
          end
        end
      end
      S_AGE_RD: begin
        rd_en      = 1'b1;
        state_next = S_AGE_WR;
      end
      S_AGE_WR: begin
        wr_en      = 1'b1;
        wr_addr    = idx[IW-1:0];
        wr_data    = {rd_id, alu.inc};
        idx_next   = idx_inc;
        state_next = (idx_inc == count) ? S_IDLE : S_AGE_RD;
      end
      S_MAX_RD: begin
        rd_en      = 1'b1;
        state_next = S_MAX_EV;
      end
      S_MAX_EV: begin
        if (nrem == '0 || alu.gt) begin
          max_wait_next = rd_wait;
          nrem_next     = CW'(1);
        end else if (alu.eq) begin
          nrem_next = nrem + CW'(1);
        end
        if (idx_inc == count) begin
          idx_next   = '0;
          keep_next  = '0;
          done_next  = '0;
          state_next = S_REM_RD;
        end else begin
          idx_next   = idx_inc;
          state_next = S_MAX_RD;
        end
      end
      S_REM_RD: begin
        rd_en      = 1'b1;
        state_next = S_REM_EV;
      end
      S_REM_EV: begin
        if (alu.eq) begin
          if (out_free) begin
            load_out  = 1'b1;
            o_status  = ST_REMOVED;
            o_id      = rd_id;
            o_wait    = rd_wait;
            o_last    = (done + CW'(1)) == nrem;
            done_next = done + CW'(1);
            advance   = 1'b1;
          end
        end else begin
          wr_en     = 1'b1;
          wr_addr   = keep[IW-1:0];
          wr_data   = rd_data;
          keep_next = keep + CW'(1);
          advance   = 1'b1;
        end
        if (advance) begin
          idx_next = idx_inc;
          if (idx_inc == count) begin
            count_next = keep_next;
            state_next = S_IDLE;
          end else begin
            state_next = S_REM_RD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx      <= idx_next;
    keep     <= keep_next;
    nrem     <= nrem_next;
    done     <= done_next;
    max_wait <= max_wait_next;
    if (load_out) begin
      m_tuser <= o_status;
      m_tdata <= {o_wait, o_id};
      m_tlast <= o_last;
    end
  end

endmodule

// ===== design/alwq_alu.sv =====
// Shared wait unit: saturating increment and compare against the running maximum.
module alwq_alu
  import alwq_pkg::*;
(
  input  logic [WAIT_W-1:0] wait_in,
  input  logic [WAIT_W-1:0] ref_wait,
  output alu_res_t          res
);

  always_comb begin
    res.inc = (wait_in == WAIT_MAX) ? wait_in : wait_in + WAIT_W'(1);
    res.gt  = wait_in > ref_wait;
    res.eq  = wait_in == ref_wait;
  end

endmodule

// ===== tb/aging_longest_wait_queue_tb.sv =====
// Self-checking testbench for the aging longest-wait queue: directed and random requests.
`timescale 1ns / 1ps

module aging_longest_wait_queue_tb;
  import alwq_pkg::*;

  localparam int DEPTH      = 16;
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_LEN   = 300;
  localparam int RAND_ITEMS = 220;

  typedef struct packed {
    logic [1:0]        status;
    logic [ID_W-1:0]   out_id;
    logic [WAIT_W-1:0] out_wait;
    logic              last;
  } result_t;

  class queue_scoreboard;
    logic [ID_W-1:0]   ids[DEPTH];
    logic [WAIT_W-1:0] waits[DEPTH];
    int                count;
    result_t           expected[$];
    int                errors;

    function new();
      count  = 0;
      errors = 0;
    endfunction

    function void report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endfunction

    function void push_result(logic [1:0] st, logic [ID_W-1:0] pid,
                              logic [WAIT_W-1:0] w, logic lst);
      result_t r;
      r.status   = st;
      r.out_id   = pid;
      r.out_wait = w;
      r.last     = lst;
      expected.push_back(r);
    endfunction

    function void note_request(logic func, logic [ID_W-1:0] pid,
                               logic [WAIT_W-1:0] init_wait);
      logic [WAIT_W-1:0] top;
      int nmatch;
      int done;
      int keep;
      if (func == FUNC_INSERT) begin
        if (count >= DEPTH) begin
          push_result(ST_FULL, '0, '0, 1'b1);
        end else begin
          ids[count]   = pid;
          waits[count] = init_wait;
          count++;
          for (int i = 0; i < count; i++)
            if (waits[i] != WAIT_MAX) waits[i] = waits[i] + 1'b1;
          push_result(ST_INSERTED, '0, '0, 1'b1);
        end
      end else if (count == 0) begin
        push_result(ST_EMPTY, '0, '0, 1'b1);
      end else begin
        top = waits[0];
        for (int i = 1; i < count; i++)
          if (waits[i] > top) top = waits[i];
        nmatch = 0;
        for (int i = 0; i < count; i++)
          if (waits[i] == top) nmatch++;
        done = 0;
        keep = 0;
        for (int i = 0; i < count; i++) begin
          if (waits[i] == top) begin
            done++;
            push_result(ST_REMOVED, ids[i], waits[i], done == nmatch);
          end else begin
            ids[keep]   = ids[i];
            waits[keep] = waits[i];
            keep++;
          end
        end
        count = keep;
      end
    endfunction

    function void check_result(logic [1:0] st, logic [ID_W-1:0] pid,
                               logic [WAIT_W-1:0] w, logic lst);
      result_t e;
      if (expected.size() == 0) begin
        report($sformatf("unexpected result status=%0d id=%h wait=%h last=%b",
                         st, pid, w, lst));
        return;
      end
      e = expected.pop_front();
      if (st !== e.status)
        report($sformatf("status got %0d exp %0d", st, e.status));
      if (pid !== e.out_id)
        report($sformatf("out_id got %h exp %h", pid, e.out_id));
      if (w !== e.out_wait)
        report($sformatf("out_wait got %h exp %h", w, e.out_wait));
      if (lst !== e.last)
        report($sformatf("last got %b exp %b", lst, e.last));
    endfunction

    function int pending();
      return expected.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;   // process_id, initial_wait
  logic [0:0]             s_tuser;   // func
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;   // out_id, out_wait
  logic [1:0]             m_tuser;   // status
  logic                   m_tlast;

  queue_scoreboard sb = new();

  int sent_total = 0;
  int snd_burst  = 0;
  int rcv_burst  = 0;
  bit hold_done  = 0;

  aging_longest_wait_queue #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // random gaps, with occasional back-to-back stretches
  function automatic int pick_gap(inout int burst_left);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst_left = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  task automatic send_req(logic func, logic [ID_W-1:0] pid, logic [WAIT_W-1:0] iw);
    int gap;
    gap = pick_gap(snd_burst);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {iw, pid};
    s_tuser  <= func;
    do @(posedge clk); while (!s_tready);
    sb.note_request(func, pid, iw);
    sent_total++;
  endtask

  function automatic logic [WAIT_W-1:0] pick_wait(int mode);
    case (mode)
      0: return WAIT_W'($urandom_range(0, 3));
      1: return WAIT_W'($urandom_range(0, 40));
      2: return WAIT_W'($urandom_range(65530, 65535));
      default: return WAIT_W'($urandom);
    endcase
  endfunction

  // receiver
  initial begin
    int gap;
    m_tready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      gap = pick_gap(rcv_burst);
      if (!hold_done && sent_total >= 40) begin
        hold_done = 1;
        gap = HOLD_LEN;
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_result(m_tuser, m_tdata[ID_W-1:0], m_tdata[ID_W+WAIT_W-1:ID_W], m_tlast);
    end
  end

  // watchdog on handshake activity
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
      else idle++;
    end
    $display("timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
    $display("[aging_longest_wait_queue] ERROR");
    $finish;
  end

  initial begin
    int bias;
    int wmode;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= FUNC_INSERT;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: empty remove, saturation, ties, full queue, 16-way remove
    send_req(FUNC_REMOVE, 16'h0000, 16'h0000);
    send_req(FUNC_INSERT, 16'hFFFF, 16'hFFFF);
    send_req(FUNC_INSERT, 16'h0000, 16'hFFFE);
    send_req(FUNC_REMOVE, 16'hFFFF, 16'hFFFF);
    send_req(FUNC_INSERT, 16'h5A5A, 16'h0000);
    send_req(FUNC_REMOVE, 16'h0000, 16'h0000);
    for (int k = 0; k < DEPTH; k++)
      send_req(FUNC_INSERT,
               (k == 0) ? 16'h0000 : (k == DEPTH - 1) ? 16'hFFFF : ID_W'($urandom),
               WAIT_W'(100 + k));
    send_req(FUNC_INSERT, 16'h1234, 16'h0000);
    send_req(FUNC_REMOVE, 16'h0000, 16'h0000);

    // random phases with varying insert/remove mix and wait distributions
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 20 == 0) begin
        case ($urandom_range(0, 3))
          0: bias = 20;
          1: bias = 50;
          2: bias = 80;
          default: bias = 95;
        endcase
        wmode = $urandom_range(0, 3);
      end
      send_req(($urandom_range(1, 100) <= bias) ? FUNC_INSERT : FUNC_REMOVE,
               ID_W'($urandom),
               ($urandom_range(0, 4) == 0) ? WAIT_W'($urandom) : pick_wait(wmode));
    end

    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.errors == 0)
      $display("[aging_longest_wait_queue] OK");
    else
      $display("[aging_longest_wait_queue] ERROR");
    $finish;
  end

endmodule

// ===== aging_longest_wait_queue.f =====
design/alwq_pkg.sv
design/alwq_alu.sv
design/aging_longest_wait_queue.sv
tb/aging_longest_wait_queue_tb.sv
